// ===== rtl/core/telnet_receive_negotiator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TELNET_RECEIVE_NEGOTIATOR_CORE_ASSERT_SVH
`define TELNET_RECEIVE_NEGOTIATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TRN_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TRN_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TRN_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define TRN_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== rtl/core/trn_pkg.sv =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator package
// Shared codes, types and constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package trn_pkg;

  localparam int TERM_NAME_LEN_DEFAULT = 14;
  localparam int QUEUE_DEPTH_DEFAULT   = 4;
  localparam int STEP_W                = 6;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] O_BINARY  = 8'd0;
  localparam logic [7:0] O_ECHO    = 8'd1;
  localparam logic [7:0] O_SGA     = 8'd3;
  localparam logic [7:0] O_TTYPE   = 8'd24;
  localparam logic [7:0] O_NAWS    = 8'd31;
  localparam logic [7:0] O_CHARSET = 8'd42;
  localparam logic [7:0] O_MCCP2   = 8'd86;

  localparam logic [7:0] SUB_SEND     = 8'd1;
  localparam logic [7:0] SUB_IS       = 8'd0;
  localparam logic [7:0] SUB_ACCEPTED = 8'd2;
  localparam logic [7:0] SUB_REJECTED = 8'd3;

  localparam logic REG_WINDOW_WIDTH  = 1'b0;
  localparam logic REG_WINDOW_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    PS_DATA   = 3'd0,
    PS_IAC    = 3'd1,
    PS_OPT    = 3'd2,
    PS_SB     = 3'd3,
    PS_SBDATA = 3'd4,
    PS_SBIAC  = 3'd5
  } parse_state_t;

  typedef enum logic [2:0] {
    JOB_DATA      = 3'd0,
    JOB_REPLY3    = 3'd1,
    JOB_NAWS      = 3'd2,
    JOB_TTYPE     = 3'd3,
    JOB_CS_ACCEPT = 3'd4,
    JOB_CS_REJECT = 3'd5,
    JOB_MCCP      = 3'd6
  } job_kind_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_REPLY    = 2'd1,
    KIND_COMPRESS = 2'd2
  } out_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] arg0;
    logic [7:0] arg1;
    logic       echo;
  } job_t;

  function automatic logic [7:0] term_char(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd0:    c = "x";
      6'd1:    c = "t";
      6'd2:    c = "e";
      6'd3:    c = "r";
      6'd4:    c = "m";
      6'd5:    c = "-";
      6'd6:    c = "2";
      6'd7:    c = "5";
      6'd8:    c = "6";
      6'd9:    c = "c";
      6'd10:   c = "o";
      6'd11:   c = "l";
      6'd12:   c = "o";
      6'd13:   c = "r";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] dashed_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "U";
      3'd1:    c = "T";
      3'd2:    c = "F";
      3'd3:    c = "-";
      3'd4:    c = "8";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] plain_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "U";
      2'd1:    c = "T";
      2'd2:    c = "F";
      default: c = "8";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/trn_front.sv =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator front end
// Parses one rx byte per cycle while not full; queues jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trn_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          full,
  output logic               push,
  output trn_pkg::job_t      job
);

  trn_pkg::parse_state_t parse_state, parse_state_next;
  logic [7:0] sub_option, sub_option_next;
  logic [1:0] sub_length, sub_length_next;
  logic [7:0] sub_first, sub_first_next;
  logic [7:0] sub_separator, sub_separator_next;
  logic [2:0] token_length, token_length_next;
  logic       token_matches_dashed, token_matches_dashed_next;
  logic       token_matches_plain, token_matches_plain_next;
  logic       charset_found, charset_found_next;
  logic       peer_echo_on, peer_echo_on_next;

  logic       accept;
  logic       job_valid;
  logic       is_cmd;
  logic       sub_take;
  logic       token_hit;
  logic [7:0] up;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept && job_valid;

  assign is_cmd = (rx_byte == trn_pkg::B_WILL) || (rx_byte == trn_pkg::B_WONT) ||
                  (rx_byte == trn_pkg::B_DO) || (rx_byte == trn_pkg::B_DONT);
  assign token_hit = (token_matches_dashed && token_length == 3'd5) ||
                     (token_matches_plain && token_length == 3'd4);
  assign up = (rx_byte >= "a" && rx_byte <= "z") ? rx_byte - 8'd32 : rx_byte;
  assign sub_take = (parse_state == trn_pkg::PS_SBDATA && rx_byte != trn_pkg::B_IAC) ||
                    (parse_state == trn_pkg::PS_SBIAC && rx_byte == trn_pkg::B_IAC);

  always_comb begin
    unique case (parse_state)
      trn_pkg::PS_IAC: begin
        if (is_cmd) parse_state_next = trn_pkg::PS_OPT;
        else if (rx_byte == trn_pkg::B_SB) parse_state_next = trn_pkg::PS_SB;
        else parse_state_next = trn_pkg::PS_DATA;
      end
      trn_pkg::PS_OPT:    parse_state_next = trn_pkg::PS_DATA;
      trn_pkg::PS_SB:     parse_state_next = trn_pkg::PS_SBDATA;
      trn_pkg::PS_SBDATA: begin
        parse_state_next = (rx_byte == trn_pkg::B_IAC) ? trn_pkg::PS_SBIAC
                                                       : trn_pkg::PS_SBDATA;
      end
      trn_pkg::PS_SBIAC: begin
        parse_state_next = (rx_byte == trn_pkg::B_IAC) ? trn_pkg::PS_SBDATA
                                                       : trn_pkg::PS_DATA;
      end
      default: begin
        parse_state_next = (rx_byte == trn_pkg::B_IAC) ? trn_pkg::PS_IAC
                                                       : trn_pkg::PS_DATA;
      end
    endcase
  end

  always_comb begin
    sub_option_next           = sub_option;
    sub_length_next           = sub_length;
    sub_first_next            = sub_first;
    sub_separator_next        = sub_separator;
    token_length_next         = token_length;
    token_matches_dashed_next = token_matches_dashed;
    token_matches_plain_next  = token_matches_plain;
    charset_found_next        = charset_found;
    peer_echo_on_next         = peer_echo_on;
    job_valid                 = 1'b0;
    job.kind                  = trn_pkg::JOB_DATA;
    job.arg0                  = rx_byte;
    job.arg1                  = rx_byte;

    if (sub_take) begin
      if (sub_length == 2'd0) begin
        sub_first_next  = rx_byte;
        sub_length_next = 2'd1;
      end else if (sub_length == 2'd1) begin
        sub_separator_next = rx_byte;
        sub_length_next    = 2'd2;
      end else if (rx_byte == sub_separator) begin
        if (token_hit) charset_found_next = 1'b1;
        token_length_next         = 3'd0;
        token_matches_dashed_next = 1'b1;
        token_matches_plain_next  = 1'b1;
      end else begin
        token_matches_dashed_next = token_matches_dashed && token_length < 3'd5 &&
                                    up == trn_pkg::dashed_char(token_length);
        token_matches_plain_next  = token_matches_plain && token_length < 3'd4 &&
                                    up == trn_pkg::plain_char(token_length[1:0]);
        if (token_length < 3'd6) token_length_next = token_length + 3'd1;
      end
    end

    unique case (parse_state)
      trn_pkg::PS_IAC: begin
        if (is_cmd) sub_option_next = rx_byte;
        if (rx_byte == trn_pkg::B_IAC) job_valid = 1'b1;
      end
      trn_pkg::PS_OPT: begin
        job_valid = 1'b1;
        job.kind  = trn_pkg::JOB_REPLY3;
        job.arg1  = rx_byte;
        if (sub_option == trn_pkg::B_WILL) begin
          if (rx_byte == trn_pkg::O_ECHO) peer_echo_on_next = 1'b1;
          if (rx_byte == trn_pkg::O_ECHO || rx_byte == trn_pkg::O_BINARY ||
              rx_byte == trn_pkg::O_CHARSET || rx_byte == trn_pkg::O_SGA ||
              rx_byte == trn_pkg::O_MCCP2) begin
            job.arg0 = trn_pkg::B_DO;
          end else begin
            job.arg0 = trn_pkg::B_DONT;
          end
        end else if (sub_option == trn_pkg::B_WONT) begin
          if (rx_byte == trn_pkg::O_ECHO) peer_echo_on_next = 1'b0;
          job.arg0 = trn_pkg::B_DONT;
        end else if (sub_option == trn_pkg::B_DO) begin
          if (rx_byte == trn_pkg::O_TTYPE || rx_byte == trn_pkg::O_BINARY) begin
            job.arg0 = trn_pkg::B_WILL;
          end else if (rx_byte == trn_pkg::O_NAWS) begin
            job.kind = trn_pkg::JOB_NAWS;
            job.arg0 = trn_pkg::B_WILL;
          end else begin
            job.arg0 = trn_pkg::B_WONT;
          end
        end else begin
          job.arg0 = trn_pkg::B_WONT;
        end
      end
      trn_pkg::PS_SB: begin
        sub_option_next           = rx_byte;
        sub_length_next           = 2'd0;
        sub_first_next            = 8'd0;
        sub_separator_next        = 8'd0;
        token_length_next         = 3'd0;
        token_matches_dashed_next = 1'b1;
        token_matches_plain_next  = 1'b1;
        charset_found_next        = 1'b0;
      end
      trn_pkg::PS_SBDATA: begin
      end
      trn_pkg::PS_SBIAC: begin
        if (rx_byte == trn_pkg::B_SE) begin
          if (sub_option == trn_pkg::O_TTYPE && sub_length != 2'd0 &&
              sub_first == trn_pkg::SUB_SEND) begin
            job_valid = 1'b1;
            job.kind  = trn_pkg::JOB_TTYPE;
          end else if (sub_option == trn_pkg::O_CHARSET && sub_length == 2'd2 &&
                       sub_first == trn_pkg::SUB_SEND) begin
            job_valid = 1'b1;
            job.kind  = (charset_found || token_hit) ? trn_pkg::JOB_CS_ACCEPT
                                                     : trn_pkg::JOB_CS_REJECT;
            charset_found_next        = charset_found || token_hit;
            token_length_next         = 3'd0;
            token_matches_dashed_next = 1'b1;
            token_matches_plain_next  = 1'b1;
          end else if (sub_option == trn_pkg::O_MCCP2 && sub_length == 2'd0) begin
            job_valid = 1'b1;
            job.kind  = trn_pkg::JOB_MCCP;
          end
        end
      end
      default: begin
        if (rx_byte != trn_pkg::B_IAC) job_valid = 1'b1;
      end
    endcase

    job.echo = peer_echo_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state          <= trn_pkg::PS_DATA;
      sub_option           <= 8'd0;
      sub_length           <= 2'd0;
      sub_first            <= 8'd0;
      sub_separator        <= 8'd0;
      token_length         <= 3'd0;
      token_matches_dashed <= 1'b1;
      token_matches_plain  <= 1'b1;
      charset_found        <= 1'b0;
      peer_echo_on         <= 1'b0;
    end else if (accept) begin
      parse_state          <= parse_state_next;
      sub_option           <= sub_option_next;
      sub_length           <= sub_length_next;
      sub_first            <= sub_first_next;
      sub_separator        <= sub_separator_next;
      token_length         <= token_length_next;
      token_matches_dashed <= token_matches_dashed_next;
      token_matches_plain  <= token_matches_plain_next;
      charset_found        <= charset_found_next;
      peer_echo_on         <= peer_echo_on_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trn_queue.sv =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator job queue
// Short register FIFO between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telnet_receive_negotiator_core_assert.svh"

module trn_queue #(
  parameter int DEPTH = trn_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire trn_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output trn_pkg::job_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  trn_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  `TRN_ASSERT_IMP(a_no_push_full, clk, rst, push, !full)
  `TRN_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty)

endmodule

`default_nettype wire

// ===== rtl/core/trn_back.sv =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator back end
// Expands queued jobs into output register bytes, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telnet_receive_negotiator_core_assert.svh"

module trn_back #(
  parameter int TERM_NAME_LEN = trn_pkg::TERM_NAME_LEN_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire trn_pkg::job_t head,
  output logic               pop,
  input  wire logic [15:0]   window_width,
  input  wire logic [15:0]   window_height,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic               last_of_run,
  output logic               peer_echo
);

  localparam int SW = trn_pkg::STEP_W;
  localparam logic [SW-1:0] NAME_END   = SW'(TERM_NAME_LEN + 4);
  localparam logic [SW-1:0] TTYPE_LAST = SW'(TERM_NAME_LEN + 5);

  logic [SW-1:0] step, step_next;
  logic [SW-1:0] rel;
  logic          load;
  logic          last;
  logic [7:0]    gen_byte;
  logic [7:0]    win_byte;
  trn_pkg::out_kind_t gen_kind;
  logic          skip_dup;

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && last;
  assign rel  = step - SW'(6);

  always_comb begin
    case (rel[2:1])
      2'd0:    win_byte = window_width[15:8];
      2'd1:    win_byte = window_width[7:0];
      2'd2:    win_byte = window_height[15:8];
      default: win_byte = window_height[7:0];
    endcase
  end

  always_comb begin
    gen_byte = 8'd0;
    gen_kind = trn_pkg::KIND_REPLY;
    last     = 1'b0;
    skip_dup = 1'b0;
    unique case (head.kind)
      trn_pkg::JOB_DATA: begin
        gen_byte = head.arg0;
        gen_kind = trn_pkg::KIND_DATA;
        last     = 1'b1;
      end
      trn_pkg::JOB_REPLY3: begin
        case (step)
          SW'(0):  gen_byte = trn_pkg::B_IAC;
          SW'(1):  gen_byte = head.arg0;
          default: gen_byte = head.arg1;
        endcase
        last = (step == SW'(2));
      end
      trn_pkg::JOB_NAWS: begin
        case (step)
          SW'(0):  gen_byte = trn_pkg::B_IAC;
          SW'(1):  gen_byte = trn_pkg::B_WILL;
          SW'(2):  gen_byte = trn_pkg::O_NAWS;
          SW'(3):  gen_byte = trn_pkg::B_IAC;
          SW'(4):  gen_byte = trn_pkg::B_SB;
          SW'(5):  gen_byte = trn_pkg::O_NAWS;
          SW'(14): gen_byte = trn_pkg::B_IAC;
          SW'(15): gen_byte = trn_pkg::B_SE;
          default: gen_byte = win_byte;
        endcase
        skip_dup = (step >= SW'(6)) && (step <= SW'(12)) && !step[0] &&
                   (win_byte != trn_pkg::B_IAC);
        last     = (step == SW'(15));
      end
      trn_pkg::JOB_TTYPE: begin
        if (step == SW'(0)) gen_byte = trn_pkg::B_IAC;
        else if (step == SW'(1)) gen_byte = trn_pkg::B_SB;
        else if (step == SW'(2)) gen_byte = trn_pkg::O_TTYPE;
        else if (step == SW'(3)) gen_byte = trn_pkg::SUB_IS;
        else if (step < NAME_END) gen_byte = trn_pkg::term_char(step - SW'(4));
        else if (step == NAME_END) gen_byte = trn_pkg::B_IAC;
        else gen_byte = trn_pkg::B_SE;
        last = (step == TTYPE_LAST);
      end
      trn_pkg::JOB_CS_ACCEPT: begin
        case (step)
          SW'(0):  gen_byte = trn_pkg::B_IAC;
          SW'(1):  gen_byte = trn_pkg::B_SB;
          SW'(2):  gen_byte = trn_pkg::O_CHARSET;
          SW'(3):  gen_byte = trn_pkg::SUB_ACCEPTED;
          SW'(9):  gen_byte = trn_pkg::B_IAC;
          SW'(10): gen_byte = trn_pkg::B_SE;
          default: gen_byte = trn_pkg::dashed_char(rel[2:0] + 3'd2);
        endcase
        last = (step == SW'(10));
      end
      trn_pkg::JOB_CS_REJECT: begin
        case (step)
          SW'(0):  gen_byte = trn_pkg::B_IAC;
          SW'(1):  gen_byte = trn_pkg::B_SB;
          SW'(2):  gen_byte = trn_pkg::O_CHARSET;
          SW'(3):  gen_byte = trn_pkg::SUB_REJECTED;
          SW'(4):  gen_byte = trn_pkg::B_IAC;
          default: gen_byte = trn_pkg::B_SE;
        endcase
        last = (step == SW'(5));
      end
      trn_pkg::JOB_MCCP: begin
        gen_kind = trn_pkg::KIND_COMPRESS;
        last     = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (last) step_next = '0;
    else if (skip_dup) step_next = step + SW'(2);
    else step_next = step + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      step      <= step_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= gen_byte;
      out_kind    <= gen_kind;
      last_of_run <= last;
      peer_echo   <= head.echo;
    end
  end

  `TRN_ASSERT_NXT(a_step_restart, clk, rst, pop, step == '0)
  `TRN_ASSERT_IMP(a_kind_legal, clk, rst, out_valid, out_kind != 2'd3)

endmodule

`default_nettype wire

// ===== rtl/core/telnet_receive_negotiator_core.sv =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator core
// Strips telnet commands from a received byte stream and generates replies.
// ----------------------------------------------------------------------------
// Path: an accepted byte's job enters the queue, then the output register.
// Throughput: one input byte per cycle while each byte causes at most one
// result and out_ready holds high; the reply sequencer emits one result per
// cycle while not stalled, and a queue of QUEUE_DEPTH jobs absorbs bursts.
// Reset: synchronous; parser in plain data, queue empty, output invalid,
// window size 80 x 24.
`default_nettype none

module telnet_receive_negotiator_core #(
  parameter int TERM_NAME_LEN = trn_pkg::TERM_NAME_LEN_DEFAULT,
  parameter int QUEUE_DEPTH   = trn_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic             last_of_run,
  output logic             peer_echo
);

  logic [15:0]   window_width;
  logic [15:0]   window_height;
  logic          push, full, pop, empty;
  trn_pkg::job_t push_job, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= 16'd80;
      window_height <= 16'd24;
    end else if (cfg_wen) begin
      case (cfg_index)
        trn_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data;
        default:                    window_height <= cfg_data;
      endcase
    end
  end

  trn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  trn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  trn_back #(
    .TERM_NAME_LEN (TERM_NAME_LEN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .window_width  (window_width),
    .window_height (window_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .last_of_run   (last_of_run),
    .peer_echo     (peer_echo)
  );

endmodule

`default_nettype wire

// ===== tb/sv/telnet_receive_negotiator_core_test.sv =====
// ----------------------------------------------------------------------------
// Telnet receive negotiator core testbench
// Streams directed and random telnet traffic (data, escaped IAC, option
// requests, TTYPE / CHARSET / MCCP2 subnegotiations, aborted and malformed
// sequences) into the core, predicts each data, reply and compression
// transfer, and checks the output stream in order under random idling on
// both channels and several window size settings.
// ----------------------------------------------------------------------------
module telnet_receive_negotiator_core_test;
  import trn_pkg::*;

  localparam int RUN_LIMIT = 600000;
  localparam int NAME_SENT = (TERM_NAME_LEN_DEFAULT > 40) ? 40 : TERM_NAME_LEN_DEFAULT;
  localparam logic [7:0] TERM_TEXT [14] =
    '{"x", "t", "e", "r", "m", "-", "2", "5", "6", "c", "o", "l", "o", "r"};
  localparam logic [7:0] UTF_DASHED [5] = '{"U", "T", "F", "-", "8"};
  localparam logic [7:0] UTF_PLAIN [4] = '{"U", "T", "F", "8"};

  typedef struct packed {
    logic [7:0] data;
    out_kind_t  kind;
    logic       last;
    logic       echo;
  } tx_item_t;

  class telnet_reply_board;
    parse_state_t pstate;
    logic [7:0]   sub_opt;
    logic [7:0]   sub_head;
    logic [7:0]   sub_sep;
    logic [1:0]   sub_count;
    logic [2:0]   tok_len;
    logic         tok_dashed;
    logic         tok_plain;
    logic         charset_ok;
    logic         echo_on;
    logic         naws_on;
    logic [15:0]  cols;
    logic [15:0]  rows;
    tx_item_t     pending_out [$];
    tx_item_t     run [$];
    int           faults;

    function new();
      pstate = PS_DATA;
      sub_opt = 8'd0;
      sub_head = 8'd0;
      sub_sep = 8'd0;
      sub_count = 2'd0;
      charset_ok = 1'b0;
      echo_on = 1'b0;
      naws_on = 1'b0;
      cols = 16'd80;
      rows = 16'd24;
      faults = 0;
      open_token();
    endfunction

    function void queue_tx(out_kind_t kind, logic [7:0] b);
      tx_item_t t;
      t.data = b;
      t.kind = kind;
      t.last = 1'b0;
      t.echo = 1'b0;
      run = {run, t};
    endfunction

    function void tx_triple(logic [7:0] cmd, logic [7:0] opt);
      queue_tx(KIND_REPLY, B_IAC);
      queue_tx(KIND_REPLY, cmd);
      queue_tx(KIND_REPLY, opt);
    endfunction

    function void tx_escaped(logic [7:0] b);
      queue_tx(KIND_REPLY, b);
      if (b == B_IAC) queue_tx(KIND_REPLY, B_IAC);
    endfunction

    function void open_token();
      tok_len = 3'd0;
      tok_dashed = 1'b1;
      tok_plain = 1'b1;
    endfunction

    function void close_token();
      if ((tok_dashed && tok_len == 3'd5) || (tok_plain && tok_len == 3'd4)) charset_ok = 1'b1;
      open_token();
    endfunction

    function void feed_sub(logic [7:0] b);
      logic [7:0] up;
      up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      if (sub_count == 2'd0) begin
        sub_head = b;
        sub_count = 2'd1;
      end else if (sub_count == 2'd1) begin
        sub_sep = b;
        sub_count = 2'd2;
      end else if (b == sub_sep) begin
        close_token();
      end else begin
        if (tok_dashed) tok_dashed = (tok_len < 3'd5) ? (up == UTF_DASHED[tok_len]) : 1'b0;
        if (tok_plain) tok_plain = (tok_len < 3'd4) ? (up == UTF_PLAIN[tok_len]) : 1'b0;
        if (tok_len < 3'd6) tok_len = tok_len + 3'd1;
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      run.delete();
      case (pstate)
        PS_IAC: begin
          pstate = PS_DATA;
          if (b == B_WILL || b == B_WONT || b == B_DO || b == B_DONT) begin
            sub_opt = b;
            pstate = PS_OPT;
          end else if (b == B_SB) begin
            pstate = PS_SB;
          end else if (b == B_IAC) begin
            queue_tx(KIND_DATA, B_IAC);
          end
        end
        PS_OPT: begin
          pstate = PS_DATA;
          if (sub_opt == B_WILL) begin
            if (b == O_ECHO) echo_on = 1'b1;
            if (b inside {O_ECHO, O_BINARY, O_CHARSET, O_SGA, O_MCCP2}) tx_triple(B_DO, b);
            else tx_triple(B_DONT, b);
          end else if (sub_opt == B_WONT) begin
            if (b == O_ECHO) echo_on = 1'b0;
            tx_triple(B_DONT, b);
          end else if (sub_opt == B_DO) begin
            if (b == O_TTYPE || b == O_BINARY) begin
              tx_triple(B_WILL, b);
            end else if (b == O_NAWS) begin
              tx_triple(B_WILL, b);
              naws_on = 1'b1;
              queue_tx(KIND_REPLY, B_IAC);
              queue_tx(KIND_REPLY, B_SB);
              queue_tx(KIND_REPLY, O_NAWS);
              tx_escaped(cols[15:8]);
              tx_escaped(cols[7:0]);
              tx_escaped(rows[15:8]);
              tx_escaped(rows[7:0]);
              queue_tx(KIND_REPLY, B_IAC);
              queue_tx(KIND_REPLY, B_SE);
            end else begin
              tx_triple(B_WONT, b);
            end
          end else begin
            tx_triple(B_WONT, b);
          end
        end
        PS_SB: begin
          sub_opt = b;
          sub_count = 2'd0;
          sub_head = 8'd0;
          sub_sep = 8'd0;
          open_token();
          charset_ok = 1'b0;
          pstate = PS_SBDATA;
        end
        PS_SBDATA: begin
          if (b == B_IAC) pstate = PS_SBIAC;
          else feed_sub(b);
        end
        PS_SBIAC: begin
          pstate = PS_DATA;
          if (b == B_SE) begin
            if (sub_opt == O_TTYPE && sub_count >= 2'd1 && sub_head == SUB_SEND) begin
              queue_tx(KIND_REPLY, B_IAC);
              queue_tx(KIND_REPLY, B_SB);
              queue_tx(KIND_REPLY, O_TTYPE);
              queue_tx(KIND_REPLY, SUB_IS);
              for (int i = 0; i < NAME_SENT; i++) begin
                queue_tx(KIND_REPLY, (i < 14) ? TERM_TEXT[i] : 8'd0);
              end
              queue_tx(KIND_REPLY, B_IAC);
              queue_tx(KIND_REPLY, B_SE);
            end else if (sub_opt == O_CHARSET && sub_count == 2'd2 && sub_head == SUB_SEND) begin
              close_token();
              queue_tx(KIND_REPLY, B_IAC);
              queue_tx(KIND_REPLY, B_SB);
              queue_tx(KIND_REPLY, O_CHARSET);
              if (charset_ok) begin
                queue_tx(KIND_REPLY, SUB_ACCEPTED);
                for (int i = 0; i < 5; i++) queue_tx(KIND_REPLY, UTF_DASHED[i]);
              end else begin
                queue_tx(KIND_REPLY, SUB_REJECTED);
              end
              queue_tx(KIND_REPLY, B_IAC);
              queue_tx(KIND_REPLY, B_SE);
            end else if (sub_opt == O_MCCP2 && sub_count == 2'd0) begin
              queue_tx(KIND_COMPRESS, 8'd0);
            end
          end else if (b == B_IAC) begin
            feed_sub(b);
            pstate = PS_SBDATA;
          end
        end
        default: begin
          pstate = (b == B_IAC) ? PS_IAC : PS_DATA;
          if (b != B_IAC) queue_tx(KIND_DATA, b);
        end
      endcase
      foreach (run[k]) begin
        run[k].echo = echo_on;
        run[k].last = (k == run.size() - 1);
        pending_out = {pending_out, run[k]};
      end
    endfunction

    function void check_out(logic [7:0] ob, logic [1:0] okind, logic olast, logic oecho);
      tx_item_t want;
      if (pending_out.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected transfer: byte %0d kind %0d last %0b echo %0b",
                   ob, okind, olast, oecho);
      end else begin
        want = pending_out[0];
        pending_out.delete(0);
        if (ob !== want.data || okind !== want.kind || olast !== want.last ||
            oecho !== want.echo) begin
          faults++;
          if (faults <= 10)
            $display("mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                     want.data, want.kind, want.last, want.echo,
                     ob, okind, olast, oecho);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic        cfg_index = REG_WINDOW_WIDTH;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        last_of_run;
  logic        peer_echo;

  telnet_reply_board board;
  int cycle_count = 0;
  int bytes_sent = 0;
  int gap_span = 4;
  int stall_span = 4;
  int stall_left = 0;
  bit calm = 1'b0;

  telnet_receive_negotiator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .last_of_run (last_of_run),
    .peer_echo   (peer_echo)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      cycle_count++;
      if (in_valid && in_ready) board.note_rx_byte(rx_byte);
      if (out_valid && out_ready) board.check_out(out_byte, out_kind, last_of_run, peer_echo);
    end
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, stall_span) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, gap_span) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_sub(input logic [7:0] b);
    send_byte(b);
    if (b == B_IAC) send_byte(B_IAC);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] w, input logic [15:0] h);
    cfg_wen <= 1'b1;
    cfg_index <= REG_WINDOW_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    board.cols = w;
    cfg_index <= REG_WINDOW_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    board.rows = h;
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 8))
      0: return O_BINARY;
      1: return O_ECHO;
      2: return O_SGA;
      3: return O_TTYPE;
      4: return O_NAWS;
      5: return O_CHARSET;
      6: return O_MCCP2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_sequence();
    int pick;
    int n;
    logic [7:0] sep;
    logic [7:0] b;
    logic [7:0] word [$];
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2: send_byte(8'($urandom_range(0, 254)));
      3: send_byte(8'($urandom_range(0, 255)));
      4: begin
        send_byte(B_IAC);
        send_byte(B_IAC);
      end
      5: begin
        send_byte(B_IAC);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
      6, 7, 8, 9: begin
        send_byte(B_IAC);
        case ($urandom_range(0, 3))
          0: send_byte(B_WILL);
          1: send_byte(B_WONT);
          2: send_byte(B_DO);
          default: send_byte(B_DONT);
        endcase
        send_byte(pick_option());
      end
      10, 11: begin
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(O_TTYPE);
        n = $urandom_range(0, 5);
        if (n >= 1 && n <= 3) send_sub(SUB_SEND);
        else if (n > 3) send_sub(8'($urandom_range(0, 255)));
        if (n != 0) repeat ($urandom_range(0, 2)) send_sub(8'($urandom_range(0, 255)));
        send_byte(B_IAC);
        send_byte(B_SE);
      end
      12, 13, 14: begin
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(O_CHARSET);
        send_sub(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : SUB_SEND);
        case ($urandom_range(0, 3))
          0: sep = ";";
          1: sep = " ";
          2: sep = ",";
          default: sep = 8'($urandom_range(0, 255));
        endcase
        repeat ($urandom_range(0, 4)) begin
          send_sub(sep);
          case ($urandom_range(0, 6))
            0: word = '{"U", "T", "F", "-", "8"};
            1: word = '{"U", "T", "F", "8"};
            2: word = '{"U", "T", "F", "-"};
            3: word = '{"U", "T", "F", "-", "8", "8"};
            4: word = '{"I", "S", "O", "-", "8", "8", "5", "9", "-", "1"};
            5: word = '{"U", "T", "F"};
            default: begin
              word.delete();
              repeat ($urandom_range(1, 7)) word = {word, 8'($urandom_range(0, 255))};
            end
          endcase
          foreach (word[k])
            if (word[k] >= "A" && word[k] <= "Z" && $urandom_range(0, 1) == 1)
              word[k] = word[k] + 8'd32;
          foreach (word[k]) send_sub(word[k]);
        end
        if ($urandom_range(0, 2) == 0) send_sub(sep);
        send_byte(B_IAC);
        send_byte(B_SE);
      end
      15: begin
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(O_MCCP2);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_sub(8'($urandom_range(0, 255)));
        send_byte(B_IAC);
        send_byte(B_SE);
      end
      16: begin
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(pick_option());
        repeat ($urandom_range(0, 4)) send_sub(8'($urandom_range(0, 255)));
        send_byte(B_IAC);
        send_byte(B_SE);
      end
      17: begin
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(pick_option());
        repeat ($urandom_range(0, 3)) send_sub(8'($urandom_range(0, 255)));
        send_byte(B_IAC);
        do b = 8'($urandom_range(0, 255)); while (b == B_SE || b == B_IAC);
        send_byte(b);
      end
      18: begin
        if ($urandom_range(0, 3) == 0) drain();
        else send_byte(8'($urandom_range(0, 254)));
      end
      default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("telnet_receive_negotiator_core_test failed");
    $finish;
  end

  initial begin
    logic [7:0] opening [$];
    int target;
    board = new();
    opening = '{8'h00, B_IAC, B_IAC, B_IAC, 8'd241, B_IAC, B_WILL, O_ECHO,
                B_IAC, B_DO, O_NAWS, B_IAC, B_SB, O_TTYPE, SUB_SEND, B_IAC, B_SE,
                B_IAC, B_SB, O_MCCP2, B_IAC, B_SE, B_IAC, B_SB, O_BINARY, B_IAC, 8'h01};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (opening[k]) send_byte(opening[k]);
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        1: begin
          set_window(16'd0, 16'd0);
          gap_span = 30;
          stall_span = 30;
        end
        2: begin
          set_window(16'hFFFF, 16'hFFFF);
          gap_span = 6;
          stall_span = 6;
        end
        3: begin
          set_window(16'h00FF, 16'hFF00);
          gap_span = 10;
          stall_span = 10;
        end
        4: begin
          set_window(16'($urandom), 16'($urandom));
          calm = 1'b1;
        end
        default: begin
          gap_span = 3;
          stall_span = 3;
        end
      endcase
      target = bytes_sent + 75;
      while (bytes_sent < target) send_sequence();
    end
    drain();
    if (board.faults == 0 && board.pending_out.size() == 0)
      $display("telnet_receive_negotiator_core_test passed");
    else
      $display("telnet_receive_negotiator_core_test failed");
    $finish;
  end

endmodule

// ===== telnet_receive_negotiator_core.f =====
+incdir+rtl/core
rtl/core/trn_pkg.sv
rtl/core/trn_front.sv
rtl/core/trn_queue.sv
rtl/core/trn_back.sv
rtl/core/telnet_receive_negotiator_core.sv
tb/sv/telnet_receive_negotiator_core_test.sv
